// ----- src/mbrc_pkg.sv -----
// mbrc_pkg: shared types, constants and the CRC-16/MODBUS byte update
// for the Modbus RTU response checker
// no dependencies
package mbrc_pkg;

    // frame length saturation and derived widths
    localparam int MAX_FRAME_BYTES = 256;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W           = 10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    // header size, frame lengths and crc size
    localparam int HDR_LEN         = 3;
    localparam int MIN_FRAME_BYTES = 5;
    localparam int WRITE_FRAME_LEN = 8;
    localparam int CRC_BYTES       = 2;

    // verdict codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CRC       = 3'd2,
        ST_ADDRESS   = 3'd3,
        ST_EXCEPTION = 3'd4,
        ST_FUNCTION  = 3'd5,
        ST_LENGTH    = 3'd6,
        ST_ECHO      = 3'd7
    } status_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SLAVE_ADDRESS     = 3'd0,
        REG_RESPONSE_KIND     = 3'd1,
        REG_EXPECTED_COUNT    = 3'd2,
        REG_EXPECTED_REGISTER = 3'd3,
        REG_EXPECTED_VALUE    = 3'd4,
        REG_READ_FUNCTION     = 3'd5,
        REG_WRITE_FUNCTION    = 3'd6,
        REG_UNUSED            = 3'd7
    } reg_index_t;

    localparam logic RESULT_PAYLOAD = 1'b0;
    localparam logic RESULT_VERDICT = 1'b1;
    localparam logic KIND_READ      = 1'b0;

    // configuration as seen by the checker core
    typedef struct packed {
        logic [7:0]  slave_address;
        logic        response_kind;
        logic [6:0]  expected_count;
        logic [15:0] expected_register;
        logic [15:0] expected_value;
        logic [6:0]  read_function_code;
        logic [6:0]  write_function_code;
    } cfg_t;

    // one result item from the core
    typedef struct packed {
        logic       valid;
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        status_t    status;
        logic [7:0] exception_code;
        logic       frame_done;
    } result_t;

    // crc-16/modbus over one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- src/mbrc_frame_check.sv -----
// mbrc_frame_check: per-frame state (crc, length, header capture) and the
// combinational payload/verdict decision for one byte
// depends on mbrc_pkg
module mbrc_frame_check (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      rx_byte,
    input  logic            end_of_frame,
    input  mbrc_pkg::cfg_t  cfg,
    output mbrc_pkg::result_t result
);
    import mbrc_pkg::*;

    logic [LEN_W-1:0] frame_length_reg, frame_length_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       address_reg, address_next;
    logic [7:0]       function_reg, function_next;
    logic [7:0]       third_reg, third_next;
    logic [15:0]      echo_reg_word_reg, echo_reg_word_next;
    logic [15:0]      echo_val_word_reg, echo_val_word_next;

    logic             counted;
    logic [CMP_W-1:0] pos_ext, len_ext, third_ext;
    logic [CMP_W-1:0] data_off;
    logic             in_data_area;
    logic [6:0]       fn;
    status_t          status;
    logic [7:0]       exc_code;

    // crc, length and header capture for this byte
    always_comb begin
        counted            = frame_length_reg < LEN_W'(MAX_FRAME_BYTES);
        crc_next           = crc16_byte(crc_reg, rx_byte);
        frame_length_next  = frame_length_reg;
        address_next       = address_reg;
        function_next      = function_reg;
        third_next         = third_reg;
        echo_reg_word_next = echo_reg_word_reg;
        echo_val_word_next = echo_val_word_reg;
        if (counted) begin
            case (frame_length_reg)
                LEN_W'(0): address_next = rx_byte;
                LEN_W'(1): function_next = rx_byte;
                LEN_W'(2): begin
                    third_next         = rx_byte;
                    echo_reg_word_next = {rx_byte, 8'h00};
                end
                LEN_W'(3): echo_reg_word_next = {echo_reg_word_reg[15:8], rx_byte};
                LEN_W'(4): echo_val_word_next = {rx_byte, 8'h00};
                LEN_W'(5): echo_val_word_next = {echo_val_word_reg[15:8], rx_byte};
                default: ;
            endcase
            frame_length_next = frame_length_reg + LEN_W'(1);
        end
    end

    // verdict against the state after this byte
    always_comb begin
        pos_ext      = CMP_W'(frame_length_reg);
        len_ext      = CMP_W'(frame_length_next);
        third_ext    = CMP_W'(third_next);
        data_off     = pos_ext - CMP_W'(HDR_LEN);
        in_data_area = (pos_ext >= CMP_W'(HDR_LEN)) && (data_off < CMP_W'(third_reg));
        fn           = cfg.response_kind ? cfg.write_function_code : cfg.read_function_code;
        status       = ST_OK;
        exc_code     = 8'h00;
        if (len_ext < CMP_W'(MIN_FRAME_BYTES)) begin
            status = ST_SHORT;
        end else if (crc_next != 16'h0000) begin
            status = ST_CRC;
        end else if (address_next != cfg.slave_address) begin
            status = ST_ADDRESS;
        end else if (function_next == ({1'b0, fn} | EXC_FLAG)) begin
            status   = ST_EXCEPTION;
            exc_code = third_next;
        end else if (function_next != {1'b0, fn}) begin
            status = ST_FUNCTION;
        end else if (cfg.response_kind == KIND_READ) begin
            if (third_next != {cfg.expected_count, 1'b0} ||
                len_ext != third_ext + CMP_W'(MIN_FRAME_BYTES)) begin
                status = ST_LENGTH;
            end
        end else begin
            if (len_ext != CMP_W'(WRITE_FRAME_LEN)) begin
                status = ST_LENGTH;
            end else if (echo_reg_word_next != cfg.expected_register ||
                         echo_val_word_next != cfg.expected_value) begin
                status = ST_ECHO;
            end
        end
    end

    // result item for this byte
    always_comb begin
        result = '0;
        if (end_of_frame) begin
            result.valid          = 1'b1;
            result.result_kind    = RESULT_VERDICT;
            result.status         = status;
            result.exception_code = exc_code;
            result.frame_done     = 1'b1;
        end else begin
            result.valid         = (cfg.response_kind == KIND_READ) && counted && in_data_area;
            result.result_kind   = RESULT_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.payload_index = data_off[7:0];
            result.status        = ST_OK;
        end
    end

    // frame state, cleared after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && end_of_frame)) begin
            frame_length_reg  <= '0;
            crc_reg           <= CRC_INIT;
            address_reg       <= '0;
            function_reg      <= '0;
            third_reg         <= '0;
            echo_reg_word_reg <= '0;
            echo_val_word_reg <= '0;
        end else if (step) begin
            frame_length_reg  <= frame_length_next;
            crc_reg           <= crc_next;
            address_reg       <= address_next;
            function_reg      <= function_next;
            third_reg         <= third_next;
            echo_reg_word_reg <= echo_reg_word_next;
            echo_val_word_reg <= echo_val_word_next;
        end
    end

endmodule

// ----- src/modbus_response_checker_unit.sv -----
// modbus_response_checker_unit: top level of the Modbus RTU response checker
// depends on mbrc_pkg and mbrc_frame_check
//
// Usage: the bytes of one received response frame enter on the s_ channel,
// one item per byte, s_tlast on the final byte. For a read response the
// register data bytes come out on the m_ channel as tentative payload items
// (m_tuser low) while the frame streams in; the final byte gives one verdict
// item (m_tuser high, m_tlast high) with the status code and, for an
// exception, the exception code. Bytes outside the data area give no item.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wr_data while no
// frame is in flight; unknown indexes are ignored.
// An accepted byte passes the input register, then the result register, on
// its way to the m_ channel. Throughput: one byte per cycle while m_tready
// stays high, set by the byte-wide crc network and frame state update.
// Reset (aresetn low, synchronous) loads the register defaults, clears the
// frame state and empties both registers. When the receiver stalls, the
// result register holds its item and the input register still takes one more
// byte; s_tready drops only when both are full.
module modbus_response_checker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // end_of_frame
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [18:16] status,
    // [26:19] exception_code, [31:27] zero
    output logic [31:0] m_tdata,
    output logic        m_tuser,   // result_kind
    output logic        m_tlast,   // frame_done
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);
    import mbrc_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       advance;
    logic       step;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address       <= 8'd1;
            cfg_reg.response_kind       <= KIND_READ;
            cfg_reg.expected_count      <= 7'd1;
            cfg_reg.expected_register   <= 16'd0;
            cfg_reg.expected_value      <= 16'd0;
            cfg_reg.read_function_code  <= 7'd3;
            cfg_reg.write_function_code <= 7'd6;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_addr))
                REG_SLAVE_ADDRESS:     cfg_reg.slave_address       <= cfg_wr_data[7:0];
                REG_RESPONSE_KIND:     cfg_reg.response_kind       <= cfg_wr_data[0];
                REG_EXPECTED_COUNT:    cfg_reg.expected_count      <= cfg_wr_data[6:0];
                REG_EXPECTED_REGISTER: cfg_reg.expected_register   <= cfg_wr_data;
                REG_EXPECTED_VALUE:    cfg_reg.expected_value      <= cfg_wr_data;
                REG_READ_FUNCTION:     cfg_reg.read_function_code  <= cfg_wr_data[6:0];
                REG_WRITE_FUNCTION:    cfg_reg.write_function_code <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // pipeline moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mbrc_frame_check u_frame_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .end_of_frame (in_last_reg),
        .cfg          (cfg_reg),
        .result       (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.exception_code, out_reg.status,
                       out_reg.payload_index, out_reg.payload_byte};
    assign m_tuser  = out_reg.result_kind;
    assign m_tlast  = out_reg.frame_done;

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for modbus_response_checker_unit
// streams directed and random response frames, predicts payload and verdict items
// depends on mbrc_pkg and the checker rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrc_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int IDLE_PCT      = 9;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BYTES  = 180;
    localparam int CYCLE_LIMIT   = 400_000;

    // shapes of response frame the generator can build
    typedef enum {
        FORM_GOOD, FORM_EXCEPTION, FORM_SHORT, FORM_BAD_CRC, FORM_BAD_ADDR,
        FORM_BAD_FUNC, FORM_BAD_LEN, FORM_BAD_ECHO, FORM_LONG, FORM_NOISE
    } frame_form_e;

    typedef enum { ROW_CFG, ROW_FRAME } row_op_e;

    typedef logic [7:0] octet_q_t[$];

    // one item on the result channel
    typedef struct packed {
        logic       kind;
        logic [7:0] pbyte;
        logic [7:0] pidx;
        status_t    status;
        logic [7:0] exc;
        logic       done;
    } reply_t;

    // one row of the directed plan
    typedef struct {
        row_op_e     op;
        reg_index_t  idx;
        logic [15:0] data;
        frame_form_e form;
        int          arg;
        bit          typed;
        status_t     st;
        logic [7:0]  exc;
    } step_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] rx_byte
    logic        s_tlast;     // end_of_frame
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [7:0] payload_byte, [15:8] payload_index,
                              // [18:16] status, [26:19] exception_code
    logic        m_tuser;     // result_kind
    logic        m_tlast;     // frame_done
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wr_data;

    // predictor state
    cfg_t             shadow_cfg;
    logic [LEN_W-1:0] frame_len;
    logic [15:0]      crc_acc;
    logic [7:0]       hdr_addr;
    logic [7:0]       hdr_func;
    logic [7:0]       hdr_third;
    logic [15:0]      echo_reg;
    logic [15:0]      echo_val;

    reply_t pending_replies[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     hush = 1'b0;

    step_row_t directed_plan [31] = '{
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_GOOD,      0,   1'b1, ST_OK,        8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_SHORT,     1,   1'b1, ST_SHORT,     8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_SHORT,     4,   1'b1, ST_SHORT,     8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_BAD_CRC,   0,   1'b1, ST_CRC,       8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_BAD_ADDR,  0,   1'b1, ST_ADDRESS,   8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_EXCEPTION, 255, 1'b1, ST_EXCEPTION, 8'hFF},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_EXCEPTION, 0,   1'b1, ST_EXCEPTION, 8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_BAD_FUNC,  0,   1'b1, ST_FUNCTION,  8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_BAD_LEN,   0,   1'b1, ST_LENGTH,    8'h00},
        '{ROW_CFG,   REG_UNUSED,            16'hFFFF, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_SLAVE_ADDRESS,     16'h00FF, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_EXPECTED_COUNT,    16'h007D, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_READ_FUNCTION,     16'h007F, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_SHORT,     2,   1'b1, ST_SHORT,     8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_EXCEPTION, 90,  1'b1, ST_EXCEPTION, 8'h5A},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_LONG,      257, 1'b1, ST_LENGTH,    8'h00},
        '{ROW_CFG,   REG_RESPONSE_KIND,     16'h0001, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_SLAVE_ADDRESS,     16'h0000, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_EXPECTED_REGISTER, 16'hFFFF, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_EXPECTED_VALUE,    16'h0000, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_WRITE_FUNCTION,    16'h0000, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_GOOD,      0,   1'b1, ST_OK,        8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_BAD_ECHO,  0,   1'b1, ST_ECHO,      8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_BAD_LEN,   0,   1'b1, ST_LENGTH,    8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_EXCEPTION, 1,   1'b1, ST_EXCEPTION, 8'h01},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_BAD_CRC,   0,   1'b1, ST_CRC,       8'h00},
        '{ROW_CFG,   REG_RESPONSE_KIND,     16'h0000, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_EXPECTED_COUNT,    16'h0000, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_CFG,   REG_READ_FUNCTION,     16'h0003, FORM_GOOD, 0, 1'b0, ST_OK, 8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_GOOD,      0,   1'b1, ST_OK,        8'h00},
        '{ROW_FRAME, REG_UNUSED, 16'h0000, FORM_NOISE,     7,   1'b0, ST_OK,        8'h00}
    };

    modbus_response_checker_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // modbus crc, one byte folded in lsb first
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        frame_len = '0;
        crc_acc   = CRC_INIT;
        hdr_addr  = '0;
        hdr_func  = '0;
        hdr_third = '0;
        echo_reg  = '0;
        echo_val  = '0;
    endfunction

    // function code the current response kind must carry
    function automatic logic [7:0] active_func();
        return {1'b0, shadow_cfg.response_kind ? shadow_cfg.write_function_code
                                               : shadow_cfg.read_function_code};
    endfunction

    // advance the frame state by one byte; returns 1 when the byte yields an item
    function automatic bit judge_byte(input logic [7:0] b, input logic last,
                                      output reply_t r);
        int         pos;
        bit         counted;
        logic [7:0] fnc;
        status_t    st;
        logic [7:0] exc;
        pos     = int'(frame_len);
        counted = pos < MAX_FRAME_BYTES;
        r       = '0;
        crc_acc = crc16_fold(crc_acc, b);
        // capture the header and echo words while the length still counts
        if (counted) begin
            case (pos)
                0: hdr_addr = b;
                1: hdr_func = b;
                2: begin
                    hdr_third = b;
                    echo_reg  = {b, 8'h00};
                end
                3: echo_reg[7:0] = b;
                4: echo_val = {b, 8'h00};
                5: echo_val[7:0] = b;
                default: ;
            endcase
            frame_len = LEN_W'(pos + 1);
        end
        // tentative payload in read mode
        if (!last) begin
            if (shadow_cfg.response_kind == KIND_READ && counted && pos >= HDR_LEN
                    && pos - HDR_LEN < int'(hdr_third)) begin
                r.kind  = RESULT_PAYLOAD;
                r.pbyte = b;
                r.pidx  = 8'(pos - HDR_LEN);
                return 1'b1;
            end
            return 1'b0;
        end
        // verdict, first failing check wins
        fnc = active_func();
        exc = 8'h00;
        if (int'(frame_len) < MIN_FRAME_BYTES) begin
            st = ST_SHORT;
        end else if (crc_acc != 16'h0000) begin
            st = ST_CRC;
        end else if (hdr_addr != shadow_cfg.slave_address) begin
            st = ST_ADDRESS;
        end else if (hdr_func == (fnc | EXC_FLAG)) begin
            st  = ST_EXCEPTION;
            exc = hdr_third;
        end else if (hdr_func != fnc) begin
            st = ST_FUNCTION;
        end else if (shadow_cfg.response_kind == KIND_READ) begin
            if (int'(hdr_third) != 2 * int'(shadow_cfg.expected_count)
                    || int'(frame_len) != int'(hdr_third) + HDR_LEN + CRC_BYTES) begin
                st = ST_LENGTH;
            end else begin
                st = ST_OK;
            end
        end else if (int'(frame_len) != WRITE_FRAME_LEN) begin
            st = ST_LENGTH;
        end else if (echo_reg != shadow_cfg.expected_register
                || echo_val != shadow_cfg.expected_value) begin
            st = ST_ECHO;
        end else begin
            st = ST_OK;
        end
        r.kind   = RESULT_VERDICT;
        r.status = st;
        r.exc    = exc;
        r.done   = 1'b1;
        clear_frame_state();
        return 1'b1;
    endfunction

    // build the bytes of one response frame for the current settings
    function automatic octet_q_t shape_frame(input frame_form_e form, input int arg);
        octet_q_t    q;
        logic [7:0]  fnc;
        logic [15:0] c;
        int          nbytes;
        int          spot;
        fnc = active_func();
        case (form)
            FORM_SHORT, FORM_NOISE: begin
                repeat (arg) q.push_back(8'($urandom));
                return q;
            end
            FORM_EXCEPTION: begin
                q = '{shadow_cfg.slave_address, fnc | EXC_FLAG, 8'(arg)};
            end
            FORM_LONG: begin
                q = '{shadow_cfg.slave_address, fnc, 8'hFF};
                while (q.size() < arg - CRC_BYTES) q.push_back(8'($urandom));
            end
            default: begin
                if (shadow_cfg.response_kind == KIND_READ) begin
                    nbytes = 2 * int'(shadow_cfg.expected_count)
                             + ((form == FORM_BAD_LEN) ? 1 : 0);
                    q = '{shadow_cfg.slave_address, fnc, 8'(nbytes)};
                    repeat (nbytes) q.push_back(8'($urandom));
                end else begin
                    q = '{shadow_cfg.slave_address, fnc,
                          shadow_cfg.expected_register[15:8],
                          shadow_cfg.expected_register[7:0],
                          shadow_cfg.expected_value[15:8],
                          shadow_cfg.expected_value[7:0]};
                    if (form == FORM_BAD_LEN) q.push_back(8'($urandom));
                    if (form == FORM_BAD_ECHO) begin
                        spot    = $urandom_range(2, 5);
                        q[spot] = q[spot] ^ 8'($urandom_range(1, 255));
                    end
                end
                if (form == FORM_BAD_ADDR) q[0] = q[0] ^ 8'($urandom_range(1, 255));
                if (form == FORM_BAD_FUNC) q[1] = fnc ^ 8'h01;
            end
        endcase
        // append the crc low byte first
        c = CRC_INIT;
        foreach (q[i]) c = crc16_fold(c, q[i]);
        q.push_back(c[7:0]);
        q.push_back(c[15:8]);
        if (form == FORM_BAD_CRC) begin
            spot    = $urandom_range(0, q.size() - 1);
            q[spot] = q[spot] ^ 8'($urandom_range(1, 255));
        end
        return q;
    endfunction

    // register write; the block is idle whenever this is called
    task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_SLAVE_ADDRESS:     shadow_cfg.slave_address       = data[7:0];
            REG_RESPONSE_KIND:     shadow_cfg.response_kind       = data[0];
            REG_EXPECTED_COUNT:    shadow_cfg.expected_count      = data[6:0];
            REG_EXPECTED_REGISTER: shadow_cfg.expected_register   = data;
            REG_EXPECTED_VALUE:    shadow_cfg.expected_value      = data;
            REG_READ_FUNCTION:     shadow_cfg.read_function_code  = data[6:0];
            REG_WRITE_FUNCTION:    shadow_cfg.write_function_code = data[6:0];
            default: ;
        endcase
    endtask

    // offer one byte, wait for the handshake, then record what it should yield
    task automatic offer_byte(input logic [7:0] b, input logic last, input bit typed,
                              input status_t st, input logic [7:0] exc);
        reply_t r;
        while (!hush && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (judge_byte(b, last, r)) begin
            if (last && typed) begin
                r.status = st;
                r.exc    = exc;
            end
            pending_replies.push_back(r);
        end
    endtask

    task automatic push_frame(input octet_q_t q, input bit typed, input status_t st,
                              input logic [7:0] exc);
        foreach (q[i]) offer_byte(q[i], i == q.size() - 1, typed, st, exc);
    endtask

    // drop valid and let every pending item drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= hush || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = m_tuser;
            got.pbyte  = m_tdata[7:0];
            got.pidx   = m_tdata[15:8];
            got.status = status_t'(m_tdata[18:16]);
            got.exc    = m_tdata[26:19];
            got.done   = m_tlast;
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected item: kind %0d byte %02h index %0d status %0d",
                             got.kind, got.pbyte, got.pidx, got.status);
                end
            end else begin
                want = pending_replies.pop_front();
                if (got !== want || m_tdata[31:27] !== 5'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected kind %0d byte %02h index %0d status %0d",
                                 want.kind, want.pbyte, want.pidx, want.status,
                                 " exc %02h last %0d", want.exc, want.done);
                        $display("          got      kind %0d byte %02h index %0d status %0d",
                                 got.kind, got.pbyte, got.pidx, got.status,
                                 " exc %02h last %0d pad %02h", got.exc, got.done,
                                 m_tdata[31:27]);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          random_bytes;
        int          phase_bytes;
        int          phase;
        int          pick;
        int          arg;
        frame_form_e form;
        octet_q_t    q;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_SLAVE_ADDRESS;
        cfg_wr_data = 16'h0000;
        shadow_cfg  = '{slave_address: 8'd1, response_kind: 1'b0, expected_count: 7'd1,
                        expected_register: 16'd0, expected_value: 16'd0,
                        read_function_code: 7'd3, write_function_code: 7'd6};
        clear_frame_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed plan
        foreach (directed_plan[i]) begin
            if (directed_plan[i].op == ROW_CFG) begin
                settle();
                write_reg(directed_plan[i].idx, directed_plan[i].data);
            end else begin
                push_frame(shape_frame(directed_plan[i].form, directed_plan[i].arg),
                           directed_plan[i].typed, directed_plan[i].st,
                           directed_plan[i].exc);
            end
        end

        // random phases, each with fresh settings; phase 2 runs without idling
        random_bytes = 0;
        phase        = 0;
        while (random_bytes < RANDOM_BYTES) begin
            settle();
            hush = (phase == 2);
            write_reg(REG_SLAVE_ADDRESS, {8'($urandom), 8'($urandom)});
            write_reg(REG_RESPONSE_KIND, {15'($urandom), 1'($urandom)});
            write_reg(REG_EXPECTED_COUNT, {9'($urandom),
                      ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 125))
                                                  : 7'($urandom_range(0, 5))});
            write_reg(REG_EXPECTED_REGISTER, 16'($urandom));
            write_reg(REG_EXPECTED_VALUE, 16'($urandom));
            write_reg(REG_READ_FUNCTION, {9'($urandom),
                      $urandom_range(0, 1) ? 7'd3 : 7'($urandom)});
            write_reg(REG_WRITE_FUNCTION, {9'($urandom),
                      $urandom_range(0, 1) ? 7'd6 : 7'($urandom)});
            phase_bytes = 0;
            while (phase_bytes < 64 && random_bytes < RANDOM_BYTES) begin
                pick = $urandom_range(0, 99);
                arg  = 0;
                // mostly well-formed frames, the rest broken or noise
                if (pick < 56) begin
                    form = FORM_GOOD;
                end else if (pick < 64) begin
                    form = FORM_EXCEPTION;
                    arg  = $urandom_range(0, 255);
                end else if (pick < 69) begin
                    form = FORM_SHORT;
                    arg  = $urandom_range(1, 4);
                end else if (pick < 75) begin
                    form = FORM_BAD_CRC;
                end else if (pick < 79) begin
                    form = FORM_BAD_ADDR;
                end else if (pick < 83) begin
                    form = FORM_BAD_FUNC;
                end else if (pick < 88) begin
                    form = FORM_BAD_LEN;
                end else if (pick < 93) begin
                    form = FORM_BAD_ECHO;
                end else if (pick < 94) begin
                    form = FORM_LONG;
                    arg  = $urandom_range(257, 262);
                end else begin
                    form = FORM_NOISE;
                    arg  = $urandom_range(1, 12);
                end
                q = shape_frame(form, arg);
                push_frame(q, 1'b0, ST_OK, 8'h00);
                phase_bytes  += q.size();
                random_bytes += q.size();
            end
            phase++;
        end
        settle();

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
